FILE: rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants and types for the streaming 3x3 Sobel edge detector.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int LINE_AW        = $clog2(MAX_LINE_WIDTH);
    localparam int PIX_W          = 8;
    localparam int LINE_DW        = 2 * PIX_W;
    localparam int COL_W          = LINE_AW;
    localparam int ROW_W          = 12;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 13;
    localparam int MAX_HEIGHT     = 4096;
    localparam int MIN_DIM        = 3;
    localparam int WIDTH_RESET    = 500;
    localparam int HEIGHT_RESET   = 600;
    localparam int GRAD_OFFSET    = 128;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = HEIGHT_W;
    localparam int OUT_DATA_W     = 40;
    localparam int NUM_CELLS      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // one window column, top row first
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } pix_col_t;

endpackage

FILE: rtl/sobel_line_store.sv
// ----------------------------------------------------------------------------
// sobel_line_store
// Two line buffers in one RAM: upper row in the high byte, lower row in the
// low byte. One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sobel_line_store (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [sobel_pkg::LINE_AW-1:0]   wr_addr,
    input  logic [sobel_pkg::LINE_DW-1:0]   wr_data,
    input  logic                            rd_en,
    input  logic [sobel_pkg::LINE_AW-1:0]   rd_addr,
    output logic [sobel_pkg::LINE_DW-1:0]   rd_data
);
    import sobel_pkg::*;

    logic [LINE_DW-1:0] mem [MAX_LINE_WIDTH];
    logic [LINE_DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sobel_window_cell.sv
// ----------------------------------------------------------------------------
// sobel_window_cell
// One column of the 3x3 window. Takes its neighbor's column on each shift.
// ----------------------------------------------------------------------------
module sobel_window_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  sobel_pkg::pix_col_t   col_in,
    output sobel_pkg::pix_col_t   col_out
);
    import sobel_pkg::*;

    pix_col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

FILE: rtl/sobel_gradient.sv
// ----------------------------------------------------------------------------
// sobel_gradient
// Row and column Sobel sums over three window columns, divided by 8 toward
// zero and offset by 128.
// ----------------------------------------------------------------------------
module sobel_gradient (
    input  sobel_pkg::pix_col_t           col_a,
    input  sobel_pkg::pix_col_t           col_b,
    input  sobel_pkg::pix_col_t           col_c,
    output logic [sobel_pkg::PIX_W-1:0]   row_gradient,
    output logic [sobel_pkg::PIX_W-1:0]   column_gradient
);
    import sobel_pkg::*;

    localparam int HALF_W = PIX_W + 2;
    localparam int SUM_W  = PIX_W + 3;

    function automatic logic [PIX_W-1:0] scale_sum(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] adj;
        logic signed [SUM_W-1:0] quo;
        adj = s + $signed({{(SUM_W-3){1'b0}}, {3{s[SUM_W-1]}}});
        quo = adj >>> 3;
        return quo[PIX_W-1:0] + PIX_W'(GRAD_OFFSET);
    endfunction

    function automatic logic [HALF_W-1:0] tap121(input logic [PIX_W-1:0] p0,
                                                 input logic [PIX_W-1:0] p1,
                                                 input logic [PIX_W-1:0] p2);
        return {2'b00, p0} + {1'b0, p1, 1'b0} + {2'b00, p2};
    endfunction

    logic [HALF_W-1:0]       row_pos;
    logic [HALF_W-1:0]       row_neg;
    logic [HALF_W-1:0]       col_pos;
    logic [HALF_W-1:0]       col_neg;
    logic signed [SUM_W-1:0] row_sum;
    logic signed [SUM_W-1:0] col_sum;

    always_comb
    begin
        row_pos = tap121(col_a.bot, col_b.bot, col_c.bot);
        row_neg = tap121(col_a.top, col_b.top, col_c.top);
        col_pos = tap121(col_c.top, col_c.mid, col_c.bot);
        col_neg = tap121(col_a.top, col_a.mid, col_a.bot);
        row_sum = $signed({1'b0, row_pos}) - $signed({1'b0, row_neg});
        col_sum = $signed({1'b0, col_pos}) - $signed({1'b0, col_neg});
        row_gradient    = scale_sum(row_sum);
        column_gradient = scale_sum(col_sum);
    end

endmodule

FILE: rtl/sobel_3x3_edge_stream.sv
// ----------------------------------------------------------------------------
// sobel_3x3_edge_stream
// Streaming 3x3 Sobel edge detector over 8-bit grey pixels in raster order.
//
//   channel   dir  beat fields (low bit up)
//   s_axis    in   tdata: pixel[7:0]; tuser: frame_start
//   m_axis    out  tdata: row_gradient, column_gradient, center_row,
//                         center_col, 2 zero bits; tlast: frame_end
//   cfg       in   cfg_index: 0 image_width, 1 image_height; cfg_data
//
// One pixel per clock sustained while m_axis is not stalled. Pipe: line RAM
// read into stage 1, then window cells and adder tree into the output register.
// Interior pixels give one result beat; border pixels give none.
// Reset: 500 x 600 geometry, window cleared, position at row 0 column 0.
// Line RAM holds no reset. A stall on m_axis holds the whole pipe.
// ----------------------------------------------------------------------------
module sobel_3x3_edge_stream (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sobel_pkg::PIX_W-1:0]         s_axis_tdata,   // pixel
    input  logic                                s_axis_tuser,   // frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // row_gradient, column_gradient, center_row, center_col, pad
    output logic [sobel_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,   // frame_end
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sobel_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;

    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_next;
    logic [COL_W-1:0]    col_base;
    logic [ROW_W-1:0]    row_base;
    logic [COL_W-1:0]    col_cur;
    logic [HEIGHT_W-1:0] row_inc;
    logic [HEIGHT_W-1:0] row_cur_w;
    logic [ROW_W-1:0]    row_cur;
    logic [WIDTH_W-1:0]  col_plus;
    logic [HEIGHT_W-1:0] row_plus;
    logic                cur_emit;
    logic                cur_last;

    logic                adv;
    logic                in_acc;

    logic                s1_valid_reg;
    logic                s1_fwd_reg;
    logic [LINE_DW-1:0]  s1_fwd_data_reg;
    logic [PIX_W-1:0]    s1_px_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    logic [ROW_W-1:0]    s1_crow_reg;
    logic [COL_W-1:0]    s1_ccol_reg;
    logic [LINE_DW-1:0]  ram_rdata;
    logic [LINE_DW-1:0]  s1_line;
    logic [LINE_DW-1:0]  wr_data;
    logic                wr_en;

    pix_col_t            win_col [NUM_CELLS+1];
    logic [PIX_W-1:0]    row_grad;
    logic [PIX_W-1:0]    col_grad;

    logic                m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(WIDTH_RESET);
            height_reg <= HEIGHT_W'(HEIGHT_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < WIDTH_W'(MIN_DIM))
            width_eff = WIDTH_W'(MIN_DIM);
        else if (width_reg > WIDTH_W'(MAX_LINE_WIDTH))
            width_eff = WIDTH_W'(MAX_LINE_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg < HEIGHT_W'(MIN_DIM))
            height_eff = HEIGHT_W'(MIN_DIM);
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
            height_eff = HEIGHT_W'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    // position of the incoming pixel and of the one after it
    always_comb
    begin
        col_base = s_axis_tuser ? '0 : col_reg;
        row_base = s_axis_tuser ? '0 : row_reg;

        if ({1'b0, col_base} >= width_eff)
        begin
            col_cur = '0;
            row_inc = {1'b0, row_base} + HEIGHT_W'(1);
        end
        else
        begin
            col_cur = col_base;
            row_inc = {1'b0, row_base};
        end
        row_cur_w = (row_inc >= height_eff) ? '0 : row_inc;
        row_cur   = row_cur_w[ROW_W-1:0];

        col_plus = {1'b0, col_cur} + WIDTH_W'(1);
        row_plus = {1'b0, row_cur} + HEIGHT_W'(1);
        if (col_plus >= width_eff)
        begin
            col_next = '0;
            row_next = (row_plus >= height_eff) ? '0 : row_plus[ROW_W-1:0];
        end
        else
        begin
            col_next = col_plus[COL_W-1:0];
            row_next = row_cur;
        end

        cur_emit = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        cur_last = ({1'b0, row_cur} == height_eff - HEIGHT_W'(1))
                && ({1'b0, col_cur} == width_eff - WIDTH_W'(1));
    end

    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // stage 1: line RAM read, write-back of the previous beat
    assign s1_line = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign wr_en   = adv && s1_valid_reg;
    assign wr_data = {s1_line[PIX_W-1:0], s1_px_reg};

    sobel_line_store u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (in_acc),
        .rd_addr (col_cur),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_acc;
            s1_fwd_reg   <= in_acc && wr_en && (s1_col_reg == col_cur);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fwd_data_reg <= wr_data;
        end
        if (in_acc)
        begin
            s1_px_reg   <= s_axis_tdata;
            s1_col_reg  <= col_cur;
            s1_emit_reg <= cur_emit;
            s1_last_reg <= cur_last;
            s1_crow_reg <= row_cur - ROW_W'(1);
            s1_ccol_reg <= col_cur - COL_W'(1);
        end
    end

    // window: newest column feeds a chain of column cells
    assign win_col[0] = '{top: s1_line[LINE_DW-1:PIX_W], mid: s1_line[PIX_W-1:0],
                          bot: s1_px_reg};

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        sobel_window_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (wr_en),
            .col_in   (win_col[i]),
            .col_out  (win_col[i+1])
        );
    end

    sobel_gradient u_gradient (
        .col_a           (win_col[2]),
        .col_b           (win_col[1]),
        .col_c           (win_col[0]),
        .row_gradient    (row_grad),
        .column_gradient (col_grad)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && s1_emit_reg)
        begin
            m_data_reg <= {2'b00, s1_ccol_reg, s1_crow_reg, col_grad, row_grad};
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTH
    a_fwd_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg |-> s1_valid_reg)
        else $error("line forward flagged on an empty stage");

    a_beat_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(s1_valid_reg && s1_emit_reg))
        else $error("result beat without an interior pixel behind it");

    a_grad_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg[7:0] != 8'd0 && m_data_reg[15:8] != 8'd0))
        else $error("gradient out of range");

    a_center_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg[27:16] != 12'd0 && m_data_reg[37:28] != 10'd0))
        else $error("window center on the border");
`endif

endmodule

FILE: dv/tb_sobel_3x3_edge_stream.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sobel_3x3_edge_stream
// Self-checking bench for the streaming 3x3 Sobel edge detector.
//
// Pixel beats are queued by the stimulus process and driven with random gaps.
// Gradient beats are drained with random stalls. Every accepted pixel runs
// through an in-bench copy of the line stores, window and position counters,
// and each gradient beat is compared field by field with the oldest
// prediction. A short directed part covers gradient extremes, register
// clamping, end-of-frame wrap and geometry shrunk mid-frame. Random frames of
// small geometry follow, then a tall partial frame with the height clamped
// from the top. One long output stall backs the pipe up into the pixel input.
// ----------------------------------------------------------------------------
module tb_sobel_3x3_edge_stream;

    import sobel_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 12;
    localparam int          RANDOM_ITEMS  = 440;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          HOLD_CYCLES   = 200;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_beat_t;

    typedef struct {
        logic [PIX_W-1:0] row_gradient;
        logic [PIX_W-1:0] column_gradient;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             frame_end;
    } sobel_result_t;

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata   = '0;
    logic                  s_axis_tuser   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index      = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    pixel_beat_t   pixel_q[$];
    sobel_result_t gradient_q[$];

    // in-bench copy of the block state
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]    line_upper [MAX_LINE_WIDTH];
    logic [PIX_W-1:0]    line_lower [MAX_LINE_WIDTH];
    pix_col_t            col_far;
    pix_col_t            col_near;
    int unsigned         row_pos;
    int unsigned         col_pos;

    bit          pixel_taken   = 1'b0;
    bit          result_taken  = 1'b0;
    bit          no_idle       = 1'b0;
    bit          src_armed     = 1'b0;
    int unsigned src_wait      = 0;
    int unsigned sink_wait     = 0;
    int unsigned hold_left     = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned cycle_count   = 0;
    int unsigned fail_count    = 0;
    int unsigned pixels_in     = 0;
    int unsigned results_seen  = 0;
    int unsigned frame_ends    = 0;
    int unsigned cfg_writes    = 0;

    sobel_3x3_edge_stream u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pixel
        .s_axis_tuser  (s_axis_tuser),   // frame_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // row_gradient, column_gradient, center_row, center_col, pad
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),   // frame_end
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] scale_gradient(int sum);
        return 8'(sum / 8 + GRAD_OFFSET);
    endfunction

    function automatic void sobel_predict(logic [PIX_W-1:0] px, logic fs);
        int unsigned   w;
        int unsigned   h;
        logic [7:0]    top;
        logic [7:0]    mid;
        int            gr;
        int            gc;
        sobel_result_t res;
        w = clamp_dim(width_reg, MAX_LINE_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (fs)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        top = line_upper[col_pos];
        mid = line_lower[col_pos];
        line_upper[col_pos] = mid;
        line_lower[col_pos] = px;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            gr = (int'(col_far.bot) + 2 * int'(col_near.bot) + int'(px))
               - (int'(col_far.top) + 2 * int'(col_near.top) + int'(top));
            gc = (int'(top) + 2 * int'(mid) + int'(px))
               - (int'(col_far.top) + 2 * int'(col_far.mid) + int'(col_far.bot));
            res.row_gradient    = scale_gradient(gr);
            res.column_gradient = scale_gradient(gc);
            res.center_row      = ROW_W'(row_pos - 1);
            res.center_col      = COL_W'(col_pos - 1);
            res.frame_end       = (row_pos == h - 1) && (col_pos == w - 1);
            gradient_q.push_back(res);
        end
        col_far  = col_near;
        col_near = '{top: top, mid: mid, bot: px};
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
            fail_count++;
        end
    endfunction

    // monitor: predictor on pixel beats, compare on gradient beats
    always @(posedge clk)
    begin : beat_monitor
        sobel_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d gradient beats still expected",
                     $realtime, gradient_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n)
        begin
            pixel_taken  <= s_axis_tvalid && s_axis_tready;
            result_taken <= m_axis_tvalid && m_axis_tready;
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                if (cfg_index == CFG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_W-1:0];
                else
                    height_reg = cfg_data[HEIGHT_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pixels_in++;
                sobel_predict(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (gradient_q.size() == 0)
                begin
                    $display("%0t: gradient beat with nothing expected, expected none actual %h",
                             $realtime, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = gradient_q.pop_front();
                    if (want.frame_end)
                        frame_ends++;
                    check_field("row_gradient", want.row_gradient, m_axis_tdata[7:0]);
                    check_field("column_gradient", want.column_gradient, m_axis_tdata[15:8]);
                    check_field("center_row", want.center_row, m_axis_tdata[16 +: ROW_W]);
                    check_field("center_col", want.center_col, m_axis_tdata[28 +: COL_W]);
                    check_field("frame_end", want.frame_end, m_axis_tlast);
                end
            end
        end
    end

    // pixel driver: one random gap per beat
    always @(negedge clk)
    begin : pixel_driver
        pixel_beat_t beat;
        int unsigned gap;
        if (!(s_axis_tvalid && !pixel_taken))
        begin
            if (src_wait != 0)
            begin
                src_wait      <= src_wait - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_q.size() == 0)
                s_axis_tvalid <= 1'b0;
            else
            begin
                gap = src_armed ? 0 : draw_gap();
                if (gap == 0)
                begin
                    beat = pixel_q.pop_front();
                    s_axis_tdata  <= beat.pixel;
                    s_axis_tuser  <= beat.frame_start;
                    s_axis_tvalid <= 1'b1;
                    src_armed     <= 1'b0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    src_wait      <= gap - 1;
                    src_armed     <= 1'b1;
                end
            end
        end
    end

    // result sink: random stall per beat, long hold-off on request
    always @(negedge clk)
    begin : result_sink
        int unsigned gap;
        if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served  <= holds_served + 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait     <= sink_wait - 1;
            m_axis_tready <= 1'b0;
        end
        else if (m_axis_tready && result_taken)
        begin
            gap = draw_gap();
            m_axis_tready <= (gap == 0);
            if (gap != 0)
                sink_wait <= gap - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] px, logic fs);
        pixel_q.push_back('{pixel: px, frame_start: fs});
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_axis_tvalid || src_wait != 0 || src_armed
               || gradient_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    initial
    begin : stimulus
        int unsigned w_sel;
        int unsigned h_sel;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned n_frames;
        int unsigned full;
        int unsigned len;
        int unsigned random_items;
        bit          broken;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        row_pos    = 0;
        col_pos    = 0;
        col_far    = '0;
        col_near   = '0;
        for (int i = 0; i < MAX_LINE_WIDTH; i++)
        begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // low clamp: both registers below the minimum give a 3x3 frame
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        // top row bright: most negative row gradient
        for (int i = 0; i < 9; i++)
            queue_pixel((i < 3) ? 8'hFF : 8'h00, i == 0);
        // next frame by wrap only, bottom row bright: most positive
        for (int i = 0; i < 9; i++)
            queue_pixel((i >= 6) ? 8'hFF : 8'h00, 1'b0);
        wait_drained();

        // shrink mid-frame: stop at row 3 column 3 of a 4x5 frame
        write_reg(CFG_IMAGE_WIDTH, 13'd4);
        write_reg(CFG_IMAGE_HEIGHT, 13'd5);
        for (int i = 0; i < 15; i++)
            queue_pixel(pick_pixel(), i == 0);
        wait_drained();
        // column and row both past the new geometry: wrap to row 0
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        write_reg(CFG_IMAGE_HEIGHT, 13'd4);
        for (int i = 0; i < 12; i++)
            queue_pixel(pick_pixel(), 1'b0);
        wait_drained();

        // output held off for a long stretch while pixels keep coming
        random_items = 0;
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        write_reg(CFG_IMAGE_HEIGHT, 13'd8);
        for (int i = 0; i < 72; i++)
            queue_pixel(pick_pixel(), i == 0);
        random_items += 72;
        hold_requests++;
        wait_drained();

        while (random_items < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            w_sel = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h_sel = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            w_eff = clamp_dim(w_sel, MAX_LINE_WIDTH);
            h_eff = clamp_dim(h_sel, MAX_HEIGHT);
            // bits above the width register are ignored
            write_reg(CFG_IMAGE_WIDTH, {2'($urandom), 11'(w_sel)});
            write_reg(CFG_IMAGE_HEIGHT, 13'(h_sel));
            full     = w_eff * h_eff;
            n_frames = $urandom_range(1, 3);
            broken   = 1'b1;
            for (int f = 0; f < n_frames; f++)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, full - 1) : full;
                for (int p = 0; p < len; p++)
                    queue_pixel(pick_pixel(),
                                (p == 0) ? (broken || $urandom_range(0, 1))
                                         : ($urandom_range(0, 49) == 0));
                broken = (len != full);
                random_items += len;
                if ($urandom_range(0, 5) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        // tall frame: height clamped from the top
        no_idle = 1'b0;
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        for (int i = 0; i < 60; i++)
            queue_pixel(pick_pixel(), i == 0);
        wait_drained();

        $display("Streamed %0d pixels over %0d register writes; %0d gradient beats checked,",
                 pixels_in, cfg_writes, results_seen);
        $display("%0d frame ends, widths 3..12, clamping, shrink, wrap and a long stall.",
                 frame_ends);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
